### rtl/core/hxr_pkg.sv
// ----------------------------------------------------------------------------
// hxr_pkg
// Shared types, constants and helpers for the bridge ADC serial reader.
// ----------------------------------------------------------------------------
package hxr_pkg;

  // Default number of data bits clocked out of the converter.
  localparam int SAMPLE_BITS_DEF = 24;

  // Fixed widths of the register and result fields.
  localparam int SAMPLE_W  = 24;
  localparam int TIMEOUT_W = 24;
  localparam int HALF_W    = 8;
  localparam int GAIN_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 24;

  // Reset values of the configuration registers.
  localparam logic [GAIN_W-1:0]    GAIN_RESET    = 2'd2;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 24'd100000;
  localparam logic [HALF_W-1:0]    HALF_RESET    = 8'd1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_SELECT = 2'd0,
    REG_TIMEOUT     = 2'd1,
    REG_HALF_PERIOD = 2'd2
  } cfg_reg_t;

  // Gain and channel codes.
  typedef enum logic [GAIN_W-1:0] {
    GAIN_A128 = 2'd0,
    GAIN_A64  = 2'd1,
    GAIN_B32  = 2'd2
  } gain_code_t;

  // Read sequencer phases.
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_DATA = 2'd2,
    PH_GAIN = 2'd3
  } phase_t;

  // Current register settings, passed from the register file to the sequencer.
  typedef struct packed {
    logic [GAIN_W-1:0]    gain_select;
    logic [TIMEOUT_W-1:0] timeout_ticks;
    logic [HALF_W-1:0]    half_period_ticks;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic                       sck;
    logic                       busy_res;
    logic                       sample_valid;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       timed_out;
  } res_t;

  // Number of extra clock pulses that select the next conversion's gain.
  function automatic logic [1:0] extra_pulses(input logic [GAIN_W-1:0] gain);
    logic [1:0] n;
    unique case (gain)
      GAIN_A128: n = 2'd1;
      GAIN_A64:  n = 2'd2;
      GAIN_B32:  n = 2'd3;
      default:   n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

### rtl/core/bridge_adc_serial_reader_core.sv
// ----------------------------------------------------------------------------
// bridge_adc_serial_reader_core
// Tick-driven reader for a 24-bit bridge load-cell ADC with gain selection.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+-----------------------------------
//  in      | to block  | in_valid / in_stall  | command, dout
//  out     | from block| out_valid / out_stall| sck, busy_res, sample_valid,
//          |           |                      | sample, timed_out
//  cfg     | to block  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Every tick passes through the input register and then the result register,
// and one tick is taken in every cycle while the output side is not stalled.
// The sequencer state advances only when a tick leaves the input register for
// the result register, so stalls on the output side simply freeze it.
// The input register is refilled in the same cycle that it empties, so
// in_stall rises only while a result is stalled and the input register is full.
// Reset is synchronous and clears the sequencer, both valid flags and the
// registers to their documented values; no clearing pass is needed.
// Configuration writes are always accepted (cfg_ready is tied high).
//
// Each input item is one tick of the converter interface. A start command in
// idle enters the data-ready wait; the next ticks watch dout for the low level
// or count toward the timeout. Then SAMPLE_BITS clock pulses shift the data
// in MSB first, followed by up to three gain pulses, after which the
// sign-extended sample is presented for one tick.
// ----------------------------------------------------------------------------
module bridge_adc_serial_reader_core
  import hxr_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // Tick input channel.
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       command,
  input  logic                       dout,
  // Result channel.
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       sck,
  output logic                       busy_res,
  output logic                       sample_valid,
  output logic signed [SAMPLE_W-1:0] sample,
  output logic                       timed_out,
  // Configuration write channel.
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DAT_W-1:0]       cfg_data
);

  cfg_t cfg;

  // Input register stage.
  logic in_full;
  logic in_command;
  logic in_dout;

  // Result register stage.
  res_t res_comb;
  res_t res_reg;
  logic res_full;

  // The result register can take a new result when it is empty or its
  // current transfer completes in this cycle.
  logic advance;
  logic step_en;

  assign advance  = !res_full || !out_stall;
  assign step_en  = in_full && advance;
  assign in_stall = in_full && !advance;

  hxr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hxr_seq #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .step_en (step_en),
    .command (in_command),
    .dout    (in_dout),
    .cfg     (cfg),
    .res     (res_comb)
  );

  // Input register: refilled whenever it is empty or being drained.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_command <= command;
      in_dout    <= dout;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_full <= 1'b0;
    end else if (advance) begin
      res_full <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      res_reg <= res_comb;
    end
  end

  assign out_valid    = res_full;
  assign sck          = res_reg.sck;
  assign busy_res     = res_reg.busy_res;
  assign sample_valid = res_reg.sample_valid;
  assign sample       = res_reg.sample;
  assign timed_out    = res_reg.timed_out;

  // A stalled input tick is never dropped: it stays in the input register.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_full && !advance |=> in_full)
    else $error("input tick lost while the result side was stalled");

  // A stalled result is never overwritten or dropped.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_full && out_stall |=> res_full && $stable(res_reg))
    else $error("stalled result changed");

  // A result is written exactly when a tick leaves the input register.
  a_res_fill: assert property (@(posedge clk) disable iff (rst)
    step_en |=> res_full)
    else $error("result register empty after a sequencer step");

endmodule

### rtl/core/hxr_cfg_regs.sv
// ----------------------------------------------------------------------------
// hxr_cfg_regs
// Configuration register file: gain select, data-ready timeout, half period.
// ----------------------------------------------------------------------------
module hxr_cfg_regs
  import hxr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  output cfg_t                 cfg
);

  cfg_t regs;

  // Writes are always taken.
  assign cfg_ready = 1'b1;
  assign cfg       = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.gain_select       <= GAIN_RESET;
      regs.timeout_ticks     <= TIMEOUT_RESET;
      regs.half_period_ticks <= HALF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GAIN_SELECT: regs.gain_select       <= cfg_data[GAIN_W-1:0];
        REG_TIMEOUT:     regs.timeout_ticks     <= cfg_data[TIMEOUT_W-1:0];
        REG_HALF_PERIOD: regs.half_period_ticks <= cfg_data[HALF_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/core/hxr_seq.sv
// ----------------------------------------------------------------------------
// hxr_seq
// Read sequencer: data-ready wait, data clocking, gain pulses and result.
// ----------------------------------------------------------------------------
module hxr_seq
  import hxr_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic step_en,
  input  logic command,
  input  logic dout,
  input  cfg_t cfg,
  output res_t res
);

  localparam int BIT_W = $clog2(SAMPLE_BITS + 1);

  phase_t                 phase, phase_next;
  logic [TIMEOUT_W-1:0]   wait_count, wait_count_next;
  logic [BIT_W-1:0]       bit_count, bit_count_next;
  logic [SAMPLE_BITS-1:0] shift_reg, shift_reg_next;
  logic [HALF_W-1:0]      prescale_count, prescale_count_next;
  logic                   clock_level, clock_level_next;

  logic [HALF_W-1:0] hp;
  logic [HALF_W-1:0] pre_inc;
  logic [BIT_W-1:0]  gain_bits;
  logic              done;
  logic              tmo;

  // A zero half period behaves as one tick.
  assign hp      = (cfg.half_period_ticks == '0) ? HALF_W'(1) : cfg.half_period_ticks;
  assign pre_inc = prescale_count + HALF_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      wait_count     <= '0;
      bit_count      <= '0;
      shift_reg      <= '0;
      prescale_count <= '0;
      clock_level    <= 1'b0;
    end else if (step_en) begin
      phase          <= phase_next;
      wait_count     <= wait_count_next;
      bit_count      <= bit_count_next;
      shift_reg      <= shift_reg_next;
      prescale_count <= prescale_count_next;
      clock_level    <= clock_level_next;
    end
  end

  // Next state.
  always_comb begin
    phase_next          = phase;
    wait_count_next     = wait_count;
    bit_count_next      = bit_count;
    shift_reg_next      = shift_reg;
    prescale_count_next = prescale_count;
    clock_level_next    = clock_level;
    gain_bits           = bit_count;
    done                = 1'b0;
    tmo                 = 1'b0;
    unique case (phase)
      PH_IDLE: begin
        if (command) begin
          phase_next          = PH_WAIT;
          wait_count_next     = '0;
          bit_count_next      = '0;
          shift_reg_next      = '0;
          prescale_count_next = '0;
          clock_level_next    = 1'b0;
        end
      end
      PH_WAIT: begin
        if (!dout) begin
          phase_next          = PH_DATA;
          prescale_count_next = '0;
          clock_level_next    = 1'b1;
        end else if (wait_count >= cfg.timeout_ticks) begin
          tmo             = 1'b1;
          phase_next      = PH_IDLE;
          wait_count_next = '0;
        end else begin
          wait_count_next = wait_count + TIMEOUT_W'(1);
        end
      end
      PH_DATA, PH_GAIN: begin
        if (pre_inc < hp) begin
          prescale_count_next = pre_inc;
        end else begin
          prescale_count_next = '0;
          if (clock_level) begin
            // Data is taken on the last tick of the high phase.
            if (phase == PH_DATA) begin
              shift_reg_next = {shift_reg[SAMPLE_BITS-2:0], dout};
            end
            bit_count_next   = bit_count + BIT_W'(1);
            clock_level_next = 1'b0;
          end else if (phase == PH_DATA && bit_count < BIT_W'(SAMPLE_BITS)) begin
            clock_level_next = 1'b1;
          end else begin
            gain_bits      = (phase == PH_DATA) ? '0 : bit_count;
            phase_next     = PH_GAIN;
            bit_count_next = gain_bits;
            if (gain_bits < BIT_W'(extra_pulses(cfg.gain_select))) begin
              clock_level_next = 1'b1;
            end else begin
              done           = 1'b1;
              phase_next     = PH_IDLE;
              bit_count_next = '0;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Result of this tick, describing the state after it.
  always_comb begin
    res.sck          = clock_level_next;
    res.busy_res     = (phase_next != PH_IDLE);
    res.sample_valid = done;
    res.sample       = done ? SAMPLE_W'($signed(shift_reg)) : '0;
    res.timed_out    = tmo;
  end

  // A finished sample always returns the sequencer to idle.
  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    step_en && done |=> phase == PH_IDLE && !clock_level)
    else $error("sequencer not idle after a finished sample");

  // The serial clock is held low while idle or waiting for data ready.
  a_clock_low: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE || phase == PH_WAIT) |-> !clock_level)
    else $error("serial clock high outside data or gain phase");

  // A timeout can only come out of the data-ready wait.
  a_tmo_from_wait: assert property (@(posedge clk) disable iff (rst)
    tmo |-> phase == PH_WAIT && dout && !done)
    else $error("timeout flagged outside the data-ready wait");

endmodule
